FILE: rtl/core/tsw_pkg.sv
// Shared types and constants for the touch stopwatch servo block.
`default_nettype none

package tsw_pkg;

    // Field widths
    localparam int TICK_W  = 16;
    localparam int ANGLE_W = 8;
    localparam int HOUR_W  = 7;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_INTERVAL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_ANGLE      = 8'd3;

    // Configuration reset values
    localparam logic [TICK_W-1:0]  RST_SECOND_INTERVAL = 16'd1000;
    localparam logic [TICK_W-1:0]  RST_SHORT_PRESS     = 16'd500;
    localparam logic [ANGLE_W-1:0] RST_ANGLE_STEP      = 8'd3;
    localparam logic [ANGLE_W-1:0] RST_FULL_ANGLE      = 8'd180;

    // Time limits
    localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;
    localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;
    localparam logic [HOUR_W-1:0] HOUR_MAX  = 7'd99;
    localparam logic [TICK_W-1:0] TICK_SAT  = 16'hFFFF;

    // Press decision handed from the press detector to the time keeper
    typedef struct packed {
        logic start;
        logic clear;
    } t_press_evt;

    // Live configuration
    typedef struct packed {
        logic [TICK_W-1:0]  second_interval;
        logic [TICK_W-1:0]  short_press_limit;
        logic [ANGLE_W-1:0] angle_step;
        logic [ANGLE_W-1:0] full_angle;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic [ANGLE_W-1:0] hand_angle;
        logic [HOUR_W-1:0]  hours;
        logic [MIN_W-1:0]   minutes;
        logic [SEC_W-1:0]   seconds;
        logic               is_running;
        logic               second_advanced;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/tsw_press.sv
// Touch press detector: times a press and classifies it on release.
`default_nettype none

module tsw_press (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic                       i_touch,
    input  wire logic                       i_running,
    input  wire logic [tsw_pkg::TICK_W-1:0] i_limit,
    output tsw_pkg::t_press_evt             o_evt
);
    import tsw_pkg::*;

    logic              r_prev, n_prev;
    logic              r_active, n_active;
    logic [TICK_W-1:0] r_len, n_len;

    // Press tracking and release decision
    always_comb begin
        n_prev   = i_touch;
        n_active = r_active;
        n_len    = r_len;
        o_evt    = '0;
        if (i_touch && !r_prev && !r_active) begin
            n_active = 1'b1;
            n_len    = {{(TICK_W-1){1'b0}}, 1'b1};
        end else if (i_touch && r_active) begin
            if (r_len != TICK_SAT) begin
                n_len = r_len + 1'b1;
            end
        end else if (!i_touch && r_active) begin
            n_active = 1'b0;
            if (!i_running) begin
                o_evt.start = (r_len < i_limit);
                o_evt.clear = !(r_len < i_limit);
            end else if (r_len > i_limit) begin
                o_evt.clear = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 1'b0;
            r_active <= 1'b0;
            r_len    <= '0;
        end else if (i_accept) begin
            r_prev   <= n_prev;
            r_active <= n_active;
            r_len    <= n_len;
        end
    end

    // A decision only comes out of a live press
    a_evt_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.start || o_evt.clear) |-> r_active)
        else $error("press event without an active press");

endmodule

`default_nettype wire

FILE: rtl/core/tsw_time.sv
// Time keeper: tick counter, hand angle and hours:minutes:seconds.
`default_nettype none

module tsw_time (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  tsw_pkg::t_press_evt      i_evt,
    input  tsw_pkg::t_cfg            i_cfg,
    output logic                     o_running,
    output tsw_pkg::t_result         o_result
);
    import tsw_pkg::*;

    logic               r_running, n_running;
    logic [TICK_W-1:0]  r_tick, n_tick;
    logic [ANGLE_W-1:0] r_angle, n_angle;
    logic [HOUR_W-1:0]  r_hour, n_hour;
    logic [MIN_W-1:0]   r_min, n_min;
    logic [SEC_W-1:0]   r_sec, n_sec;
    logic               n_adv;
    logic [ANGLE_W:0]   angle_sum;

    assign angle_sum = {1'b0, r_angle} + {1'b0, i_cfg.angle_step};

    // Next state for one tick
    always_comb begin
        n_running = r_running;
        n_tick    = r_tick;
        n_angle   = r_angle;
        n_hour    = r_hour;
        n_min     = r_min;
        n_sec     = r_sec;
        n_adv     = 1'b0;
        if (i_evt.clear) begin
            n_running = 1'b0;
            n_tick    = '0;
            n_angle   = '0;
            n_hour    = '0;
            n_min     = '0;
            n_sec     = '0;
        end else if (i_evt.start) begin
            n_running = 1'b1;
            n_tick    = '0;
        end else if (r_running) begin
            if (r_tick != TICK_SAT) begin
                n_tick = r_tick + 1'b1;
            end
            if (r_angle >= i_cfg.full_angle) begin
                // hand at full scale snaps back
                n_angle = '0;
            end else if (n_tick >= i_cfg.second_interval) begin
                n_angle = (angle_sum > {1'b0, i_cfg.full_angle}) ?
                          i_cfg.full_angle : angle_sum[ANGLE_W-1:0];
                n_tick  = '0;
                n_adv   = 1'b1;
                if (r_sec >= SEC_LAST) begin
                    n_sec = '0;
                    if (r_min >= MIN_LAST) begin
                        n_min = '0;
                        if (r_hour < HOUR_MAX) begin
                            n_hour = r_hour + 1'b1;
                        end
                    end else begin
                        n_min = r_min + 1'b1;
                    end
                end else begin
                    n_sec = r_sec + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_tick    <= '0;
            r_angle   <= '0;
            r_hour    <= '0;
            r_min     <= '0;
            r_sec     <= '0;
        end else if (i_accept) begin
            r_running <= n_running;
            r_tick    <= n_tick;
            r_angle   <= n_angle;
            r_hour    <= n_hour;
            r_min     <= n_min;
            r_sec     <= n_sec;
        end
    end

    assign o_running = r_running;

    always_comb begin
        o_result.hand_angle      = n_angle;
        o_result.hours           = n_hour;
        o_result.minutes         = n_min;
        o_result.seconds         = n_sec;
        o_result.is_running      = n_running;
        o_result.second_advanced = n_adv;
    end

    // Time stays in range and only moves while running
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hour <= HOUR_MAX) && (r_min <= MIN_LAST) && (r_sec <= SEC_LAST))
        else $error("elapsed time out of range");
    a_adv_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_adv |-> (r_running && !i_evt.start && !i_evt.clear))
        else $error("second counted while stopped");

endmodule

`default_nettype wire

FILE: rtl/core/tsw_out_buf.sv
// Two-entry result buffer between the time keeper and the output channel.
`default_nettype none

module tsw_out_buf (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  tsw_pkg::t_result  i_data,
    output logic              o_full,
    output logic              o_valid,
    input  wire logic         i_stall,
    output tsw_pkg::t_result  o_data
);
    import tsw_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_mem[r_rd_ptr];

    // Payload storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

    // Never overfilled, and the count matches the pointer distance
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= 2'd2) && !(o_full && i_push))
        else $error("result buffer overflow");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr ^ r_rd_ptr) == r_count[0])
        else $error("result buffer pointers disagree with fill level");

endmodule

`default_nettype wire

FILE: rtl/core/touch_stopwatch_servo.sv
// Touch stopwatch servo top level: configuration registers and channel handshakes.
`default_nettype none

// Each input item is one millisecond tick with the sampled touch level, and it
// produces exactly one result item: the hand angle, the elapsed time and run
// status after that tick. The press detector and time keeper update their state
// at the accepting edge and the result enters a two-entry output buffer, so a
// new item is taken every cycle as long as the buffer is not full (two results
// waiting). Configuration registers come out of reset at 1000 ticks per second,
// a 500-tick short press limit, a 3-degree step and a 180-degree full scale,
// and should only be written while no item is in flight.
module touch_stopwatch_servo (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_touch_level,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [tsw_pkg::ANGLE_W-1:0]         o_hand_angle,
    output logic [tsw_pkg::HOUR_W-1:0]          o_hours,
    output logic [tsw_pkg::MIN_W-1:0]           o_minutes,
    output logic [tsw_pkg::SEC_W-1:0]           o_seconds,
    output logic                                o_is_running,
    output logic                                o_second_advanced,
    input  wire logic                           i_cfg_we,
    input  wire logic [tsw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tsw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tsw_pkg::*;

    t_cfg       r_cfg;
    t_press_evt evt;
    t_result    result;
    t_result    out_data;
    logic       accept;
    logic       running;
    logic       buf_full;

    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.second_interval   <= RST_SECOND_INTERVAL;
            r_cfg.short_press_limit <= RST_SHORT_PRESS;
            r_cfg.angle_step        <= RST_ANGLE_STEP;
            r_cfg.full_angle        <= RST_FULL_ANGLE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SECOND_INTERVAL: r_cfg.second_interval   <= i_cfg_data;
                CFG_SHORT_PRESS:     r_cfg.short_press_limit <= i_cfg_data;
                CFG_ANGLE_STEP:      r_cfg.angle_step        <= i_cfg_data[ANGLE_W-1:0];
                CFG_FULL_ANGLE:      r_cfg.full_angle        <= i_cfg_data[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    tsw_press u_press (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_touch   (i_touch_level),
        .i_running (running),
        .i_limit   (r_cfg.short_press_limit),
        .o_evt     (evt)
    );

    tsw_time u_time (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_evt     (evt),
        .i_cfg     (r_cfg),
        .o_running (running),
        .o_result  (result)
    );

    tsw_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (result),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_data)
    );

    assign o_hand_angle      = out_data.hand_angle;
    assign o_hours           = out_data.hours;
    assign o_minutes         = out_data.minutes;
    assign o_seconds         = out_data.seconds;
    assign o_is_running      = out_data.is_running;
    assign o_second_advanced = out_data.second_advanced;

    // An accepted item always shows up as a result on the next cycle
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted item produced no result");

endmodule

`default_nettype wire
